### sv/rbjq_pkg.sv
`timescale 1ns / 1ps

package rbjq_pkg;

    localparam int DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        ACT_ENQ = 2'd0,
        ACT_SEL = 2'd1,
        ACT_REP = 2'd2,
        ACT_BAD = 2'd3
    } action_t;

    // outcome codes
    localparam logic [2:0] OUTC_SUCCESS = 3'd0;
    localparam logic [2:0] OUTC_CLIENT  = 3'd4;
    localparam logic [2:0] OUTC_MISSING = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_EVICTED = 3'd2;
    localparam logic [2:0] ST_REJECT  = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    // register indexes
    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_MAX     = 2'd1;
    localparam logic [1:0] REG_SPACING = 2'd2;

    typedef struct packed {
        action_t     action;
        logic [31:0] now_time;
        logic [31:0] job_key;
        logic [31:0] job_tag;
        logic [2:0]  outcome;
        logic        key_zero;
    } cmd_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] tag;
        logic [31:0] queue_time;
        logic [31:0] retry_time;
        logic [7:0]  retries;
    } entry_t;

    typedef struct packed {
        logic [15:0] base_delay;
        logic [15:0] max_delay;
        logic [15:0] spacing;
    } cfg_t;

endpackage

### sv/rbjq_in_if.sv
`timescale 1ns / 1ps

interface rbjq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] now_time;
    logic [31:0] job_key;
    logic [31:0] job_tag;
    logic [2:0]  outcome;

    modport source (output valid, action, now_time, job_key, job_tag, outcome, input ready);
    modport sink (input valid, action, now_time, job_key, job_tag, outcome, output ready);
endinterface

### sv/rbjq_out_if.sv
`timescale 1ns / 1ps

interface rbjq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op_status;
    logic        granted;
    logic [31:0] grant_key;
    logic [31:0] grant_tag;
    logic [15:0] next_delay;
    logic [5:0]  pending_jobs;
    logic [5:0]  waiting_jobs;
    logic [31:0] oldest_queue_time;

    modport source (output valid, op_status, granted, grant_key, grant_tag, next_delay,
                    pending_jobs, waiting_jobs, oldest_queue_time, input ready);
    modport sink (input valid, op_status, granted, grant_key, grant_tag, next_delay,
                  pending_jobs, waiting_jobs, oldest_queue_time, output ready);
endinterface

### sv/rbjq_front.sv
`timescale 1ns / 1ps

module rbjq_front (
    input  logic          clk,
    input  logic          rst_n,
    rbjq_in_if.sink       job_in,
    output logic          cmd_valid,
    output rbjq_pkg::cmd_t cmd,
    input  logic          cmd_ready
);
    import rbjq_pkg::*;

    logic valid_reg;
    cmd_t cmd_reg;

    assign job_in.ready = !valid_reg || cmd_ready;
    assign cmd_valid    = valid_reg;
    assign cmd          = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (job_in.ready)
        begin
            valid_reg <= job_in.valid;
        end
    end

    // decode and classify the item
    always_ff @(posedge clk)
    begin
        if (job_in.valid && job_in.ready)
        begin
            cmd_reg.action   <= action_t'(job_in.action);
            cmd_reg.now_time <= job_in.now_time;
            cmd_reg.job_key  <= job_in.job_key;
            cmd_reg.job_tag  <= job_in.job_tag;
            cmd_reg.outcome  <= job_in.outcome;
            cmd_reg.key_zero <= (job_in.job_key == 32'd0);
        end
    end

endmodule

### sv/rbjq_queue.sv
`timescale 1ns / 1ps

module rbjq_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  rbjq_pkg::cmd_t push_cmd,
    output logic           push_ready,
    output logic           pop_valid,
    output rbjq_pkg::cmd_t pop_cmd,
    input  logic           pop_ready
);
    import rbjq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/rbjq_back.sv
`timescale 1ns / 1ps

module rbjq_back #(
    parameter int TABLE_DEPTH = rbjq_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rbjq_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    input  rbjq_pkg::cmd_t cmd,
    output logic           cmd_ready,
    rbjq_out_if.source     job_out
);
    import rbjq_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_BACKOFF,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_UPDATE,
        S_STAT,
        S_OUT
    } state_t;

    entry_t mem [TABLE_DEPTH];
    entry_t mem_q_reg;
    logic   we;
    logic [AW-1:0] wa;
    entry_t wd;
    logic [AW-1:0] ra;

    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          pend_reg;
    logic [AW-1:0] pidx_reg;
    logic          found_reg;
    logic [AW-1:0] best_reg;
    logic [31:0]   best_q_reg;
    entry_t        hit_reg;
    logic          append_reg;
    logic [31:0]   last_reg;
    logic [16:0]   delay_reg;
    logic [7:0]    bcnt_reg;
    logic [CW-1:0] waiting_reg;
    logic [31:0]   oldest_reg;
    logic [2:0]    status_reg;
    logic          granted_reg;
    logic [31:0]   gkey_reg;
    logic [31:0]   gtag_reg;
    logic [15:0]   dly_out_reg;
    logic          out_valid_reg;

    logic          issue;
    logic          scan_done;
    logic          blocked;
    logic [15:0]   capped;
    logic [32:0]   rsum;
    logic [7:0]    new_retries;
    logic [CW-1:0] idx_inc;

    assign cmd_ready = (state_reg == S_IDLE);
    assign issue     = (idx_reg < count_reg);
    assign scan_done = !issue && !pend_reg;
    assign idx_inc   = idx_reg + CW'(1);

    // grant spacing since last success, signed difference
    always_comb
    begin
        logic signed [33:0] diff;
        diff    = $signed({2'b00, cmd_reg.now_time}) - $signed({2'b00, last_reg});
        blocked = (last_reg != 32'd0) && (diff < $signed({18'd0, cfg.spacing}));
    end

    assign capped      = (delay_reg > {1'b0, cfg.max_delay}) ? cfg.max_delay : delay_reg[15:0];
    assign rsum        = {1'b0, cmd_reg.now_time} + {17'd0, capped};
    assign new_retries = (hit_reg.retries == 8'hff) ? hit_reg.retries : hit_reg.retries + 8'd1;

    // memory port control
    always_comb
    begin
        we = 1'b0;
        wa = best_reg;
        wd = hit_reg;
        ra = idx_reg[AW-1:0];
        unique case (state_reg)
            S_SHIFT_RD:
            begin
                ra = idx_inc[AW-1:0];
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                wa = idx_reg[AW-1:0];
                wd = mem_q_reg;
            end
            S_APPEND:
            begin
                we = 1'b1;
                wa = count_reg[AW-1:0];
                wd = '{key: cmd_reg.job_key, tag: cmd_reg.job_tag,
                       queue_time: cmd_reg.now_time, retry_time: 32'd0, retries: 8'd0};
            end
            S_UPDATE:
            begin
                we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg     <= cmd;
                        idx_reg     <= '0;
                        pend_reg    <= 1'b0;
                        found_reg   <= 1'b0;
                        best_reg    <= '0;
                        best_q_reg  <= 32'd0;
                        append_reg  <= 1'b0;
                        granted_reg <= 1'b0;
                        gkey_reg    <= 32'd0;
                        gtag_reg    <= 32'd0;
                        dly_out_reg <= 16'd0;
                        waiting_reg <= '0;
                        oldest_reg  <= 32'd0;
                        if (cmd.action == ACT_BAD || (cmd.action == ACT_ENQ && cmd.key_zero))
                        begin
                            status_reg <= ST_REJECT;
                            state_reg  <= S_STAT;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_reg <= issue;
                    pidx_reg <= idx_reg[AW-1:0];
                    if (issue)
                    begin
                        idx_reg <= idx_inc;
                    end
                    if (pend_reg)
                    begin
                        unique case (cmd_reg.action)
                            ACT_ENQ:
                            begin
                                if (mem_q_reg.key == cmd_reg.job_key)
                                begin
                                    found_reg <= 1'b1;
                                end
                                if (pidx_reg == '0 || mem_q_reg.queue_time < best_q_reg)
                                begin
                                    best_reg   <= pidx_reg;
                                    best_q_reg <= mem_q_reg.queue_time;
                                end
                            end
                            ACT_SEL:
                            begin
                                if (mem_q_reg.retry_time <= cmd_reg.now_time &&
                                    (!found_reg || mem_q_reg.queue_time < best_q_reg))
                                begin
                                    found_reg  <= 1'b1;
                                    best_reg   <= pidx_reg;
                                    best_q_reg <= mem_q_reg.queue_time;
                                    hit_reg    <= mem_q_reg;
                                end
                            end
                            default:
                            begin
                                if (!found_reg && mem_q_reg.key == cmd_reg.job_key &&
                                    mem_q_reg.tag == cmd_reg.job_tag)
                                begin
                                    found_reg <= 1'b1;
                                    best_reg  <= pidx_reg;
                                    hit_reg   <= mem_q_reg;
                                end
                            end
                        endcase
                    end
                    if (scan_done)
                    begin
                        unique case (cmd_reg.action)
                            ACT_ENQ:
                            begin
                                if (found_reg)
                                begin
                                    status_reg <= ST_DUP;
                                    idx_reg    <= '0;
                                    state_reg  <= S_STAT;
                                end
                                else if (count_reg == FULL)
                                begin
                                    status_reg <= ST_EVICTED;
                                    append_reg <= 1'b1;
                                    idx_reg    <= {{(CW-AW){1'b0}}, best_reg};
                                    state_reg  <= S_SHIFT_RD;
                                end
                                else
                                begin
                                    state_reg <= S_APPEND;
                                end
                            end
                            ACT_SEL:
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_STAT;
                                if (found_reg && !blocked)
                                begin
                                    granted_reg <= 1'b1;
                                    gkey_reg    <= hit_reg.key;
                                    gtag_reg    <= hit_reg.tag;
                                end
                                else
                                begin
                                    status_reg <= ST_NONE;
                                end
                            end
                            default:
                            begin
                                if (!found_reg)
                                begin
                                    status_reg <= ST_NONE;
                                    idx_reg    <= '0;
                                    state_reg  <= S_STAT;
                                end
                                else if (cmd_reg.outcome == OUTC_SUCCESS)
                                begin
                                    last_reg  <= cmd_reg.now_time;
                                    idx_reg   <= {{(CW-AW){1'b0}}, best_reg};
                                    state_reg <= S_SHIFT_RD;
                                end
                                else if (cmd_reg.outcome == OUTC_CLIENT ||
                                         cmd_reg.outcome == OUTC_MISSING)
                                begin
                                    idx_reg   <= {{(CW-AW){1'b0}}, best_reg};
                                    state_reg <= S_SHIFT_RD;
                                end
                                else
                                begin
                                    hit_reg.retries <= new_retries;
                                    bcnt_reg        <= new_retries;
                                    delay_reg       <= {1'b0, cfg.base_delay};
                                    state_reg       <= S_BACKOFF;
                                end
                            end
                        endcase
                    end
                end
                S_BACKOFF:
                begin
                    if (bcnt_reg != 8'd0 && delay_reg < {1'b0, cfg.max_delay})
                    begin
                        delay_reg <= {delay_reg[15:0], 1'b0};
                        bcnt_reg  <= bcnt_reg - 8'd1;
                    end
                    else
                    begin
                        dly_out_reg        <= capped;
                        hit_reg.retry_time <= rsum[32] ? 32'hffff_ffff : rsum[31:0];
                        state_reg          <= S_UPDATE;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (idx_inc < count_reg)
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (append_reg)
                        begin
                            state_reg <= S_APPEND;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            pend_reg  <= 1'b0;
                            state_reg <= S_STAT;
                        end
                    end
                end
                S_SHIFT_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_SHIFT_RD;
                end
                S_APPEND:
                begin
                    count_reg <= count_reg + CW'(1);
                    idx_reg   <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= S_STAT;
                end
                S_UPDATE:
                begin
                    idx_reg   <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= S_STAT;
                end
                S_STAT:
                begin
                    pend_reg <= issue;
                    pidx_reg <= idx_reg[AW-1:0];
                    if (issue)
                    begin
                        idx_reg <= idx_inc;
                    end
                    if (pend_reg)
                    begin
                        if (mem_q_reg.retry_time > cmd_reg.now_time)
                        begin
                            waiting_reg <= waiting_reg + CW'(1);
                        end
                        if (pidx_reg == '0 || mem_q_reg.queue_time < oldest_reg)
                        begin
                            oldest_reg <= mem_q_reg.queue_time;
                        end
                    end
                    if (scan_done)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (job_out.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign job_out.valid             = out_valid_reg;
    assign job_out.op_status         = status_reg;
    assign job_out.granted           = granted_reg;
    assign job_out.grant_key         = gkey_reg;
    assign job_out.grant_tag         = gtag_reg;
    assign job_out.next_delay        = dly_out_reg;
    assign job_out.pending_jobs      = 6'(count_reg);
    assign job_out.waiting_jobs      = 6'(waiting_reg);
    assign job_out.oldest_queue_time = oldest_reg;

endmodule

### sv/retry_backoff_job_queue_core.sv
`timescale 1ns / 1ps

// channel   | dir | handshake       | payload
// job_in    | in  | valid / ready   | action, now_time, job_key, job_tag, outcome
// job_out   | out | valid / ready   | op_status, granted, grant_key, grant_tag, next_delay,
//           |     |                 | pending_jobs, waiting_jobs, oldest_queue_time
// cfg       | in  | cfg_we          | cfg_index, cfg_data (16 bits)
//
// the table sequencer handles one item at a time: it accepts it, makes a lookup pass
// and then a count pass over the jobs, and presents the result; front and queue come first
// an append writes one entry; a removal reads and writes back each job shifted down
// a retry backoff doubles the delay per retry until it reaches the maximum delay
// reset clears the job count and last success time; table contents need no clearing
// the front register and a two-item queue keep accepting while a result is stalled

module retry_backoff_job_queue_core #(
    parameter int TABLE_DEPTH = rbjq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    rbjq_in_if.sink     job_in,
    rbjq_out_if.source  job_out
);
    import rbjq_pkg::*;

    cfg_t cfg_reg;

    // front side to queue
    logic f_valid;
    cmd_t f_cmd;
    logic f_ready;

    // queue to back side
    logic b_valid;
    cmd_t b_cmd;
    logic b_ready;

    // configuration registers; the user writes them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_delay <= 16'd60;
            cfg_reg.max_delay  <= 16'd3600;
            cfg_reg.spacing    <= 16'd30;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE:    cfg_reg.base_delay <= cfg_data;
                REG_MAX:     cfg_reg.max_delay  <= cfg_data;
                REG_SPACING: cfg_reg.spacing    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // decode stage
    rbjq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_in    (job_in),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    // decouples decode from the table sequencer
    rbjq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_cmd   (f_cmd),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_cmd    (b_cmd),
        .pop_ready  (b_ready)
    );

    // table sequencer with job memory and result register
    rbjq_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (b_valid),
        .cmd       (b_cmd),
        .cmd_ready (b_ready),
        .job_out   (job_out)
    );

endmodule

### tb/sv/tb_rbjq_ifs.sv
`timescale 1ns / 1ps

// no extra interfaces needed: the block's own channel interfaces are reused
package tb_rbjq_util_pkg;
    localparam int TB_DEPTH = 32;
endpackage

### tb/sv/tb_retry_backoff_job_queue_core.sv
`timescale 1ns / 1ps

module tb_retry_backoff_job_queue_core;
    import rbjq_pkg::*;

    localparam int DEPTH = tb_rbjq_util_pkg::TB_DEPTH;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_time;
        logic [31:0] job_key;
        logic [31:0] job_tag;
        logic [2:0]  outcome;
    } job_req_t;

    typedef struct packed {
        logic [2:0]  op_status;
        logic        granted;
        logic [31:0] grant_key;
        logic [31:0] grant_tag;
        logic [15:0] next_delay;
        logic [5:0]  pending_jobs;
        logic [5:0]  waiting_jobs;
        logic [31:0] oldest_queue_time;
    } job_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    rbjq_in_if  job_in();
    rbjq_out_if job_out();

    retry_backoff_job_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .job_in   (job_in),
        .job_out  (job_out)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // shadow of the job table, kept in insertion order
    logic [31:0] tbl_key   [DEPTH];
    logic [31:0] tbl_tag   [DEPTH];
    logic [31:0] tbl_qtime [DEPTH];
    logic [31:0] tbl_rtime [DEPTH];
    logic [7:0]  tbl_retries [DEPTH];
    int          tbl_count;
    logic [31:0] last_success;
    logic [15:0] base_delay;
    logic [15:0] max_delay;
    logic [15:0] grant_spacing;

    job_req_t pending_items[$];
    job_rsp_t expected_rsps[$];
    int       error_count;
    int       rsp_count;
    int       grant_count;
    int       evict_count;
    int       backoff_total;

    // stimulus-side view of keys in the table, for well-formed reports
    logic [31:0] live_key[$];
    logic [31:0] live_tag[$];
    logic [31:0] sim_now;

    // input handshake as seen at the rising edge
    logic in_fire;

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < tbl_count; i++)
        begin
            tbl_key[i]     = tbl_key[i + 1];
            tbl_tag[i]     = tbl_tag[i + 1];
            tbl_qtime[i]   = tbl_qtime[i + 1];
            tbl_rtime[i]   = tbl_rtime[i + 1];
            tbl_retries[i] = tbl_retries[i + 1];
        end
        tbl_count--;
    endfunction

    function automatic logic [15:0] backoff_delay(logic [7:0] n);
        logic [31:0] d;
        d = {16'd0, base_delay};
        for (int i = 0; i < n && d < max_delay; i++)
            d = d * 2;
        if (d > max_delay)
            d = {16'd0, max_delay};
        return d[15:0];
    endfunction

    // works out the result of one item and updates the shadow table
    function automatic job_rsp_t predict_job_step(job_req_t r);
        job_rsp_t o;
        logic     hit;
        int       best;
        int       idx;
        logic [32:0] t;
        longint   diff;
        o = '0;
        hit = 1'b0;
        best = 0;
        idx = 0;
        case (action_t'(r.action))
            ACT_ENQ:
            begin
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_key[i] == r.job_key)
                        hit = 1'b1;
                if (r.job_key == 0)
                    o.op_status = ST_REJECT;
                else if (hit)
                    o.op_status = ST_DUP;
                else
                begin
                    if (tbl_count >= DEPTH)
                    begin
                        for (int i = 1; i < tbl_count; i++)
                            if (tbl_qtime[i] < tbl_qtime[best])
                                best = i;
                        drop_entry(best);
                        o.op_status = ST_EVICTED;
                        evict_count++;
                    end
                    tbl_key[tbl_count]     = r.job_key;
                    tbl_tag[tbl_count]     = r.job_tag;
                    tbl_qtime[tbl_count]   = r.now_time;
                    tbl_rtime[tbl_count]   = '0;
                    tbl_retries[tbl_count] = '0;
                    tbl_count++;
                end
            end
            ACT_SEL:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_rtime[i] > r.now_time)
                        continue;
                    if (!hit || tbl_qtime[i] < tbl_qtime[best])
                    begin
                        best = i;
                        hit = 1'b1;
                    end
                end
                diff = longint'(r.now_time) - longint'(last_success);
                if (hit && last_success != 0 && diff < longint'(grant_spacing))
                    hit = 1'b0;
                if (hit)
                begin
                    o.granted = 1'b1;
                    o.grant_key = tbl_key[best];
                    o.grant_tag = tbl_tag[best];
                    grant_count++;
                end
                else
                    o.op_status = ST_NONE;
            end
            ACT_REP:
            begin
                for (int i = 0; i < tbl_count; i++)
                    if (!hit && tbl_key[i] == r.job_key && tbl_tag[i] == r.job_tag)
                    begin
                        idx = i;
                        hit = 1'b1;
                    end
                if (!hit)
                    o.op_status = ST_NONE;
                else if (r.outcome == OUTC_SUCCESS)
                begin
                    drop_entry(idx);
                    last_success = r.now_time;
                end
                else if (r.outcome == OUTC_CLIENT || r.outcome == OUTC_MISSING)
                    drop_entry(idx);
                else
                begin
                    if (tbl_retries[idx] != 8'hFF)
                        tbl_retries[idx]++;
                    o.next_delay = backoff_delay(tbl_retries[idx]);
                    t = {1'b0, r.now_time} + {17'd0, o.next_delay};
                    tbl_rtime[idx] = t[32] ? 32'hFFFF_FFFF : t[31:0];
                    backoff_total++;
                end
            end
            default:
                o.op_status = ST_REJECT;
        endcase
        o.pending_jobs = tbl_count[5:0];
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_rtime[i] > r.now_time)
                o.waiting_jobs++;
            if (i == 0 || tbl_qtime[i] < o.oldest_queue_time)
                o.oldest_queue_time = tbl_qtime[i];
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", rsp_count, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        in_fire = job_in.valid && job_in.ready;
    end

    // driver: bursts of items with random gaps
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_in.valid    <= 1'b0;
            job_in.action   <= ACT_ENQ;
            job_in.now_time <= '0;
            job_in.job_key  <= '0;
            job_in.job_tag  <= '0;
            job_in.outcome  <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            logic fire;
            job_req_t nxt;
            fire = job_in.valid && in_fire;
            if (fire)
            begin
                expected_rsps.push_back(predict_job_step(pending_items.pop_front()));
            end
            if (job_in.valid && !fire)
            begin
                // hold the current item
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                job_in.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                nxt = pending_items[0];
                job_in.valid    <= 1'b1;
                job_in.action   <= nxt.action;
                job_in.now_time <= nxt.now_time;
                job_in.job_key  <= nxt.job_key;
                job_in.job_tag  <= nxt.job_tag;
                job_in.outcome  <= nxt.outcome;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                end
            end
            else
                job_in.valid <= 1'b0;
        end
    end

    // receiver stall pattern: runs of ready and not ready
    int stall_run;
    logic stall_phase;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_out.ready <= 1'b0;
            stall_run = 0;
            stall_phase = 1'b0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_phase = !stall_phase;
                stall_run = stall_phase ? $urandom_range(1, 80) : $urandom_range(0, 50);
            end
            else
                stall_run--;
            job_out.ready <= stall_phase;
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && job_out.valid && job_out.ready)
        begin
            job_rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $display("MISMATCH unexpected result with nothing pending");
                error_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (job_out.op_status != want.op_status)
                    report_mismatch("op_status", 32'(job_out.op_status), 32'(want.op_status));
                if (job_out.granted != want.granted)
                    report_mismatch("granted", 32'(job_out.granted), 32'(want.granted));
                if (job_out.grant_key != want.grant_key)
                    report_mismatch("grant_key", job_out.grant_key, want.grant_key);
                if (job_out.grant_tag != want.grant_tag)
                    report_mismatch("grant_tag", job_out.grant_tag, want.grant_tag);
                if (job_out.next_delay != want.next_delay)
                    report_mismatch("next_delay", 32'(job_out.next_delay),
                                    32'(want.next_delay));
                if (job_out.pending_jobs != want.pending_jobs)
                    report_mismatch("pending_jobs", 32'(job_out.pending_jobs),
                                    32'(want.pending_jobs));
                if (job_out.waiting_jobs != want.waiting_jobs)
                    report_mismatch("waiting_jobs", 32'(job_out.waiting_jobs),
                                    32'(want.waiting_jobs));
                if (job_out.oldest_queue_time != want.oldest_queue_time)
                    report_mismatch("oldest_queue_time", job_out.oldest_queue_time,
                                    want.oldest_queue_time);
            end
            rsp_count++;
        end
    end

    // stimulus helpers; the initial block tracks time and live jobs loosely
    task automatic queue_item(action_t a, logic [31:0] t, logic [31:0] k,
                              logic [31:0] g, logic [2:0] oc);
        job_req_t r;
        r.action = a;
        r.now_time = t;
        r.job_key = k;
        r.job_tag = g;
        r.outcome = oc;
        pending_items.push_back(r);
        if (a == ACT_ENQ && k != 0)
        begin
            live_key.push_back(k);
            live_tag.push_back(g);
            if (live_key.size() > 40)
            begin
                void'(live_key.pop_front());
                void'(live_tag.pop_front());
            end
        end
    endtask

    // waits for the block to drain, then writes one register
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        while (pending_items.size() > 0 || expected_rsps.size() > 0 || job_in.valid)
            @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BASE:    base_delay = val;
            REG_MAX:     max_delay = val;
            REG_SPACING: grant_spacing = val;
            default:     ;
        endcase
    endtask

    // one phase of random traffic, mostly well-formed enqueue/select/report flows
    task automatic random_phase(int n);
        int pick;
        int j;
        logic [31:0] k;
        logic [2:0]  oc;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) != 0)
                sim_now = sim_now + $urandom_range(0, 300);
            else
                sim_now = $urandom();
            if (pick < 35)
            begin
                k = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 60);
                queue_item(ACT_ENQ, sim_now, k, $urandom(), 3'($urandom_range(0, 7)));
            end
            else if (pick < 55)
                queue_item(ACT_SEL, sim_now, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
            else if (pick < 92 && live_key.size() > 0)
            begin
                j = $urandom_range(0, live_key.size() - 1);
                oc = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 3));
                k = live_key[j];
                // sometimes a wrong tag, so the report is unmatched
                queue_item(ACT_REP, sim_now, k,
                           ($urandom_range(0, 9) == 0) ? $urandom() : live_tag[j], oc);
            end
            else if (pick < 97)
                queue_item(ACT_REP, sim_now, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
            else
                queue_item(ACT_BAD, sim_now, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BASE;
        cfg_data = '0;
        tbl_count = 0;
        last_success = '0;
        base_delay = 16'd60;
        max_delay = 16'd3600;
        grant_spacing = 16'd30;
        error_count = 0;
        rsp_count = 0;
        grant_count = 0;
        evict_count = 0;
        backoff_total = 0;
        sim_now = 32'd1000;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: rejects, duplicates, tie on queue time, select, spacing,
        // success at time zero, unknown outcome and action, saturating retry time
        queue_item(ACT_SEL, 32'd0, 32'd0, 32'd0, 3'd0);
        queue_item(ACT_ENQ, 32'd5, 32'd0, 32'hFFFF_FFFF, 3'd0);
        queue_item(ACT_ENQ, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        queue_item(ACT_ENQ, 32'd100, 32'd7, 32'd1, 3'd0);
        queue_item(ACT_ENQ, 32'd100, 32'd7, 32'd2, 3'd0);
        queue_item(ACT_SEL, 32'd100, 32'd0, 32'd0, 3'd0);
        queue_item(ACT_REP, 32'd0, 32'd7, 32'd1, OUTC_SUCCESS);
        queue_item(ACT_SEL, 32'd0, 32'd0, 32'd0, 3'd0);
        queue_item(ACT_REP, 32'd110, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        queue_item(ACT_SEL, 32'd110, 32'd0, 32'd0, 3'd0);
        queue_item(ACT_REP, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1);
        queue_item(ACT_REP, 32'd120, 32'hFFFF_FFFF, 32'd3, 3'd2);
        queue_item(ACT_ENQ, 32'd50, 32'd9, 32'd9, 3'd0);
        queue_item(ACT_REP, 32'd200, 32'd9, 32'd9, OUTC_SUCCESS);
        queue_item(ACT_SEL, 32'd210, 32'd0, 32'd0, 3'd0);
        queue_item(ACT_SEL, 32'd150, 32'd0, 32'd0, 3'd0);
        queue_item(ACT_SEL, 32'hFFFF_FFFF, 32'd0, 32'd0, 3'd0);
        queue_item(ACT_REP, 32'd300, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OUTC_CLIENT);
        queue_item(ACT_ENQ, 32'd1, 32'd11, 32'd1, 3'd0);
        queue_item(ACT_REP, 32'd2, 32'd11, 32'd1, OUTC_MISSING);
        queue_item(ACT_REP, 32'd2, 32'd11, 32'd1, 3'd3);
        queue_item(ACT_BAD, 32'd3, 32'd1, 32'd1, 3'd6);
        // fill past the table size to force evictions, equal queue times included
        for (int i = 0; i < 36; i++)
            queue_item(ACT_ENQ, 32'd400 + (i % 3), 32'd1000 + i, i, 3'd6);
        random_phase(250);

        // extremes of the registers
        write_reg(REG_BASE, 16'd1);
        write_reg(REG_MAX, 16'hFFFF);
        write_reg(REG_SPACING, 16'd0);
        random_phase(400);
        write_reg(REG_BASE, 16'hFFFF);
        write_reg(REG_MAX, 16'd1);
        write_reg(REG_SPACING, 16'hFFFF);
        random_phase(300);
        write_reg(REG_BASE, 16'd3);
        write_reg(REG_MAX, 16'd1000);
        write_reg(REG_SPACING, 16'd100);
        random_phase(450);
        write_reg(REG_BASE, 16'hAAAA);
        write_reg(REG_MAX, 16'h5555);
        write_reg(REG_SPACING, 16'd1);
        random_phase(400);

        while (pending_items.size() > 0 || job_in.valid)
            @(negedge clk);
        while (expected_rsps.size() > 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        $display("ran %0d results: %0d grants, %0d evictions, %0d backoff retries",
                 rsp_count, grant_count, evict_count, backoff_total);
        $display("five register settings, bursty input and stalled output");
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog: ~2000 items plus long gaps and stalls
    initial
    begin
        #100_000_000;
        $display("timeout with %0d results outstanding", expected_rsps.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
